// File: rtl/core/ssq_pkg.sv
package ssq_pkg;

   localparam int SQRT_STEPS = 32;
   localparam int DIV_STEPS  = 31;
   localparam int LANES      = 6;
   localparam int NORM_FRAC  = 14;
   localparam logic [14:0] NORM_ONE = 15'd16384;

   typedef enum logic [2:0] {
      REG_INNER_RADIUS,
      REG_OUTER_RADIUS,
      REG_CENTER_X,
      REG_CENTER_Y,
      REG_CENTER_Z
   } reg_index_type;

   typedef struct packed {
      logic signed [31:0] point_x;
      logic signed [31:0] point_y;
      logic signed [31:0] point_z;
   } req_type;

   typedef struct packed {
      logic               is_inside;
      logic               closer_surface;
      logic signed [31:0] nearest_x;
      logic signed [31:0] nearest_y;
      logic signed [31:0] nearest_z;
      logic signed [15:0] normal_x;
      logic signed [15:0] normal_y;
      logic signed [15:0] normal_z;
      logic               at_center;
   } rsp_type;

   typedef struct packed {
      logic [30:0]      inner_radius;
      logic [30:0]      outer_radius;
      logic [2:0][31:0] center;
   } cfg_type;

   typedef struct packed {
      logic in_shell;
      logic closer;
      logic centre;
      logic lt_a;
      logic gt_b;
      logic inward;
   } flag_type;

   // offset from center as magnitude and sign
   typedef struct packed {
      logic [2:0][31:0] mag;
      logic [2:0]       neg;
      flag_type         f;
   } meta_type;

endpackage

// File: rtl/core/ssq_csr.sv
module ssq_csr (
   input  logic             clock,
   input  logic             reset,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready,
   output ssq_pkg::cfg_type cfg
);
   import ssq_pkg::*;

   logic [30:0]      inner_ff;
   logic [30:0]      outer_ff;
   logic [2:0][31:0] center_ff;
   reg_index_type    idx;
   logic             wr;

   assign idx    = reg_index_type'(paddr[4:2]);
   assign wr     = psel && penable && pwrite;
   assign pready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         inner_ff  <= '0;
         outer_ff  <= '0;
         center_ff <= '0;
      end else if (wr) begin
         unique case (idx)
            REG_INNER_RADIUS: inner_ff     <= pwdata[30:0];
            REG_OUTER_RADIUS: outer_ff     <= pwdata[30:0];
            REG_CENTER_X:     center_ff[0] <= pwdata;
            REG_CENTER_Y:     center_ff[1] <= pwdata;
            REG_CENTER_Z:     center_ff[2] <= pwdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (idx)
         REG_INNER_RADIUS: prdata = {1'b0, inner_ff};
         REG_OUTER_RADIUS: prdata = {1'b0, outer_ff};
         REG_CENTER_X:     prdata = center_ff[0];
         REG_CENTER_Y:     prdata = center_ff[1];
         REG_CENTER_Z:     prdata = center_ff[2];
         default:          prdata = '0;
      endcase
   end

   assign cfg.inner_radius = inner_ff;
   assign cfg.outer_radius = outer_ff;
   assign cfg.center       = center_ff;

endmodule

// File: rtl/core/ssq_front.sv
module ssq_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  ssq_pkg::req_type  in_data,
   input  ssq_pkg::cfg_type  cfg,
   output logic              out_valid,
   output logic [63:0]       out_r2,
   output ssq_pkg::meta_type out_meta
);
   import ssq_pkg::*;

   logic [4:0] valid_ff;

   // stage 1: saturated offset
   logic [2:0][31:0] pt;
   logic [2:0][31:0] mag1_in, mag1_ff;
   logic [2:0]       neg1_in, neg1_ff;

   // stage 2: squares
   logic [2:0][63:0] sq_in, sq_ff;
   logic [61:0]      a2_in, a2_ff, b2_in, b2_ff;
   logic [31:0]      rsum;
   logic [63:0]      s2_in, s2_ff;
   logic [2:0][31:0] mag2_ff;
   logic [2:0]       neg2_ff;

   // stage 3: radius squared
   logic [63:0]      r2_3_in, r2_3_ff;
   logic [64:0]      s2_bias;
   logic [62:0]      up_in, up_ff, dn_in, dn_ff;
   logic [61:0]      a2_3_ff, b2_3_ff;
   logic [2:0][31:0] mag3_ff;
   logic [2:0]       neg3_ff;

   // stage 4: flags and distances
   flag_type         f4_in, f4_ff;
   logic [63:0]      da_in, da_ff, db_in, db_ff;
   logic [63:0]      r2_4_ff;
   logic [63:0]      a2e, b2e;
   logic [2:0][31:0] mag4_ff;
   logic [2:0]       neg4_ff;

   // stage 5: closer surface
   meta_type         meta5_in, meta5_ff;
   logic [63:0]      r2_5_ff;

   assign pt[0] = in_data.point_x;
   assign pt[1] = in_data.point_y;
   assign pt[2] = in_data.point_z;

   always_comb begin
      logic [32:0] diff;
      logic [31:0] d;
      for (int i = 0; i < 3; i++) begin
         diff = {pt[i][31], pt[i]} - {cfg.center[i][31], cfg.center[i]};
         if (diff[32] != diff[31]) d = diff[32] ? 32'h8000_0000 : 32'h7FFF_FFFF;
         else d = diff[31:0];
         neg1_in[i] = d[31];
         mag1_in[i] = d[31] ? (~d + 32'd1) : d;
      end
   end

   always_comb begin
      for (int i = 0; i < 3; i++) sq_in[i] = 64'(mag1_ff[i]) * 64'(mag1_ff[i]);
      a2_in = 62'(cfg.inner_radius) * 62'(cfg.inner_radius);
      b2_in = 62'(cfg.outer_radius) * 62'(cfg.outer_radius);
      rsum  = 32'(cfg.inner_radius) + 32'(cfg.outer_radius);
      s2_in = 64'(rsum) * 64'(rsum);
   end

   always_comb begin
      r2_3_in = sq_ff[0] + sq_ff[1] + sq_ff[2];
      s2_bias = 65'(s2_ff) + 65'd3;
      up_in   = s2_bias[64:2];
      dn_in   = s2_ff[63:2];
   end

   assign a2e = 64'(a2_3_ff);
   assign b2e = 64'(b2_3_ff);

   always_comb begin
      f4_in.in_shell = (r2_3_ff >= a2e) && (r2_3_ff <= b2e);
      f4_in.closer   = 1'b0;
      f4_in.centre   = (r2_3_ff == 64'd0);
      f4_in.lt_a     = r2_3_ff < a2e;
      f4_in.gt_b     = r2_3_ff > b2e;
      // inner surface closer on linear radius, decided on squares
      if (cfg.outer_radius > cfg.inner_radius) f4_in.inward = r2_3_ff < 64'(up_ff);
      else if (cfg.outer_radius < cfg.inner_radius) f4_in.inward = r2_3_ff > 64'(dn_ff);
      else f4_in.inward = 1'b0;
      da_in = (r2_3_ff > a2e) ? r2_3_ff - a2e : a2e - r2_3_ff;
      db_in = (r2_3_ff > b2e) ? r2_3_ff - b2e : b2e - r2_3_ff;
   end

   always_comb begin
      meta5_in.mag      = mag4_ff;
      meta5_in.neg      = neg4_ff;
      meta5_in.f        = f4_ff;
      meta5_in.f.closer = !(da_ff < db_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else if (en) begin
         valid_ff <= {valid_ff[3:0], in_valid};
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         mag1_ff  <= mag1_in;
         neg1_ff  <= neg1_in;
         sq_ff    <= sq_in;
         a2_ff    <= a2_in;
         b2_ff    <= b2_in;
         s2_ff    <= s2_in;
         mag2_ff  <= mag1_ff;
         neg2_ff  <= neg1_ff;
         r2_3_ff  <= r2_3_in;
         up_ff    <= up_in;
         dn_ff    <= dn_in;
         a2_3_ff  <= a2_ff;
         b2_3_ff  <= b2_ff;
         mag3_ff  <= mag2_ff;
         neg3_ff  <= neg2_ff;
         f4_ff    <= f4_in;
         da_ff    <= da_in;
         db_ff    <= db_in;
         r2_4_ff  <= r2_3_ff;
         mag4_ff  <= mag3_ff;
         neg4_ff  <= neg3_ff;
         meta5_ff <= meta5_in;
         r2_5_ff  <= r2_4_ff;
      end
   end

   assign out_valid = valid_ff[4];
   assign out_r2    = r2_5_ff;
   assign out_meta  = meta5_ff;

endmodule

// File: rtl/core/ssq_sqrt.sv
module ssq_sqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  logic [63:0]       in_r2,
   input  ssq_pkg::meta_type in_meta,
   output logic              out_valid,
   output logic [31:0]       out_root,
   output ssq_pkg::meta_type out_meta
);
   import ssq_pkg::*;

   logic [SQRT_STEPS-1:0] valid_ff;
   logic [63:0]           v_ff   [SQRT_STEPS];
   logic [63:0]           res_ff [SQRT_STEPS];
   meta_type              meta_ff[SQRT_STEPS];

   // one root bit per stage, from one bit pair of the radicand
   for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_step
      localparam logic [63:0] BIT = 64'd1 << (62 - 2 * k);
      logic [63:0] v_prev, res_prev, trial, v_in, res_in;
      logic        valid_prev;
      meta_type    meta_prev;

      if (k == 0) begin : g_first
         assign v_prev     = in_r2;
         assign res_prev   = '0;
         assign valid_prev = in_valid;
         assign meta_prev  = in_meta;
      end else begin : g_next
         assign v_prev     = v_ff[k-1];
         assign res_prev   = res_ff[k-1];
         assign valid_prev = valid_ff[k-1];
         assign meta_prev  = meta_ff[k-1];
      end

      always_comb begin
         trial = res_prev + BIT;
         if (v_prev >= trial) begin
            v_in   = v_prev - trial;
            res_in = (res_prev >> 1) + BIT;
         end else begin
            v_in   = v_prev;
            res_in = res_prev >> 1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            v_ff[k]    <= v_in;
            res_ff[k]  <= res_in;
            meta_ff[k] <= meta_prev;
         end
      end
   end

   assign out_valid = valid_ff[SQRT_STEPS-1];
   assign out_root  = res_ff[SQRT_STEPS-1][31:0];
   assign out_meta  = meta_ff[SQRT_STEPS-1];

endmodule

// File: rtl/core/ssq_div.sv
module ssq_div (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [31:0]                     in_root,
   input  ssq_pkg::meta_type               in_meta,
   input  ssq_pkg::cfg_type                cfg,
   output logic                            out_valid,
   output logic [ssq_pkg::LANES-1:0][ssq_pkg::DIV_STEPS-1:0] out_quot,
   output ssq_pkg::meta_type               out_meta
);
   import ssq_pkg::*;

   localparam int NUM_W = DIV_STEPS + 32;

   // prep stage: dividends for the three rescale lanes and three normal lanes
   logic                              pvalid_ff;
   logic [LANES-1:0][31:0]            prem_in, prem_ff;
   logic [LANES-1:0][DIV_STEPS-1:0]   pqn_in, pqn_ff;
   logic [31:0]                       proot_ff;
   meta_type                          pmeta_ff;

   logic [DIV_STEPS-1:0]              valid_ff;
   logic [LANES-1:0][31:0]            rem_ff [DIV_STEPS];
   logic [LANES-1:0][DIV_STEPS-1:0]   qn_ff  [DIV_STEPS];
   logic [31:0]                       root_ff[DIV_STEPS];
   meta_type                          meta_ff[DIV_STEPS];

   always_comb begin
      logic [30:0]      rad;
      logic [NUM_W-1:0] num;
      rad = in_meta.f.lt_a ? cfg.inner_radius : cfg.outer_radius;
      for (int i = 0; i < 3; i++) begin
         num = NUM_W'(in_meta.mag[i]) * NUM_W'(rad) + NUM_W'(in_root >> 1);
         prem_in[i] = num[NUM_W-1:DIV_STEPS];
         pqn_in[i]  = num[DIV_STEPS-1:0];
         num = (NUM_W'(in_meta.mag[i]) << NORM_FRAC) + NUM_W'(in_root >> 1);
         prem_in[3+i] = num[NUM_W-1:DIV_STEPS];
         pqn_in[3+i]  = num[DIV_STEPS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pvalid_ff <= 1'b0;
      end else if (en) begin
         pvalid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         prem_ff  <= prem_in;
         pqn_ff   <= pqn_in;
         proot_ff <= in_root;
         pmeta_ff <= in_meta;
      end
   end

   // restoring division, one quotient bit per stage
   for (genvar k = 0; k < DIV_STEPS; k++) begin : g_step
      logic [LANES-1:0][31:0]          rem_prev, rem_in;
      logic [LANES-1:0][DIV_STEPS-1:0] qn_prev, qn_in;
      logic [31:0]                     root_prev;
      logic                            valid_prev;
      meta_type                        meta_prev;

      if (k == 0) begin : g_first
         assign rem_prev   = prem_ff;
         assign qn_prev    = pqn_ff;
         assign root_prev  = proot_ff;
         assign valid_prev = pvalid_ff;
         assign meta_prev  = pmeta_ff;
      end else begin : g_next
         assign rem_prev   = rem_ff[k-1];
         assign qn_prev    = qn_ff[k-1];
         assign root_prev  = root_ff[k-1];
         assign valid_prev = valid_ff[k-1];
         assign meta_prev  = meta_ff[k-1];
      end

      always_comb begin
         logic [32:0] t;
         logic        q;
         for (int j = 0; j < LANES; j++) begin
            t = {rem_prev[j], qn_prev[j][DIV_STEPS-1]};
            q = t >= {1'b0, root_prev};
            rem_in[j] = q ? 32'(t - {1'b0, root_prev}) : t[31:0];
            qn_in[j]  = {qn_prev[j][DIV_STEPS-2:0], q};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            valid_ff[k] <= 1'b0;
         end else if (en) begin
            valid_ff[k] <= valid_prev;
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rem_ff[k]  <= rem_in;
            qn_ff[k]   <= qn_in;
            root_ff[k] <= root_prev;
            meta_ff[k] <= meta_prev;
         end
      end
   end

   assign out_valid = valid_ff[DIV_STEPS-1];
   assign out_quot  = qn_ff[DIV_STEPS-1];
   assign out_meta  = meta_ff[DIV_STEPS-1];

endmodule

// File: rtl/core/ssq_back.sv
module ssq_back (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            en,
   input  logic                            in_valid,
   input  logic [ssq_pkg::LANES-1:0][ssq_pkg::DIV_STEPS-1:0] in_quot,
   input  ssq_pkg::meta_type               in_meta,
   input  ssq_pkg::cfg_type                cfg,
   output logic                            out_valid,
   output ssq_pkg::rsp_type                out_data
);
   import ssq_pkg::*;

   logic             v1_ff, v2_ff;
   logic [2:0][32:0] nr_in, nr_ff;
   logic [2:0][15:0] nm_in, nm_ff, nm2_ff;
   flag_type         f1_ff, f2_ff;
   logic [2:0][31:0] near_in, near_ff;

   always_comb begin
      logic [32:0] m;
      logic [15:0] n;
      for (int i = 0; i < 3; i++) begin
         if (in_meta.f.lt_a || in_meta.f.gt_b) m = 33'(in_quot[i]);
         else m = 33'(in_meta.mag[i]);
         if (in_meta.f.centre) nr_in[i] = (i == 0) ? 33'(cfg.inner_radius) : 33'd0;
         else nr_in[i] = in_meta.neg[i] ? (~m + 33'd1) : m;

         n = (in_quot[3+i] > DIV_STEPS'(NORM_ONE)) ? 16'(NORM_ONE) : 16'(in_quot[3+i]);
         // sign of the offset, flipped again for an inward normal
         if (in_meta.f.centre) nm_in[i] = '0;
         else nm_in[i] = (in_meta.neg[i] ^ in_meta.f.inward) ? (~n + 16'd1) : n;
      end
   end

   always_comb begin
      logic [33:0] s;
      for (int i = 0; i < 3; i++) begin
         s = {nr_ff[i][32], nr_ff[i]} + {{2{cfg.center[i][31]}}, cfg.center[i]};
         if (s[33] && (s[32:31] != 2'b11)) near_in[i] = 32'h8000_0000;
         else if (!s[33] && (s[32:31] != 2'b00)) near_in[i] = 32'h7FFF_FFFF;
         else near_in[i] = s[31:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (en) begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         nr_ff   <= nr_in;
         nm_ff   <= nm_in;
         f1_ff   <= in_meta.f;
         near_ff <= near_in;
         nm2_ff  <= nm_ff;
         f2_ff   <= f1_ff;
      end
   end

   assign out_valid               = v2_ff;
   assign out_data.is_inside      = f2_ff.in_shell;
   assign out_data.closer_surface = f2_ff.closer;
   assign out_data.nearest_x      = near_ff[0];
   assign out_data.nearest_y      = near_ff[1];
   assign out_data.nearest_z      = near_ff[2];
   assign out_data.normal_x       = nm2_ff[0];
   assign out_data.normal_y       = nm2_ff[1];
   assign out_data.normal_z       = nm2_ff[2];
   assign out_data.at_center      = f2_ff.centre;

endmodule

// File: rtl/core/spherical_shell_point_query_core.sv
// The path from an accepted req transaction to rsp_valid has 5 front stages,
// 32 square-root stages, 32 divider stages and 2 output stages.
// Throughput: one transaction per cycle while rsp is not stalled; every stage does one step of work.
// A stalled rsp holds the whole pipeline and req_stall follows it.
// Reset (synchronous) clears all valid bits and the configuration registers.
module spherical_shell_point_query_core (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  ssq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output ssq_pkg::rsp_type rsp_data,
   input  logic             psel,
   input  logic             penable,
   input  logic             pwrite,
   input  logic [4:0]       paddr,
   input  logic [31:0]      pwdata,
   output logic [31:0]      prdata,
   output logic             pready
);
   import ssq_pkg::*;

   cfg_type  cfg;
   logic     en;
   logic     f_valid, s_valid, d_valid;
   logic [63:0] f_r2;
   logic [31:0] s_root;
   meta_type f_meta, s_meta, d_meta;
   logic [LANES-1:0][DIV_STEPS-1:0] d_quot;

   assign en        = !(rsp_valid && rsp_stall);
   assign req_stall = rsp_valid && rsp_stall;

   ssq_csr u_csr (
      .clock(clock), .reset(reset), .psel(psel), .penable(penable), .pwrite(pwrite),
      .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready), .cfg(cfg)
   );

   ssq_front u_front (
      .clock(clock), .reset(reset), .en(en), .in_valid(req_valid), .in_data(req_data),
      .cfg(cfg), .out_valid(f_valid), .out_r2(f_r2), .out_meta(f_meta)
   );

   ssq_sqrt u_sqrt (
      .clock(clock), .reset(reset), .en(en), .in_valid(f_valid), .in_r2(f_r2),
      .in_meta(f_meta), .out_valid(s_valid), .out_root(s_root), .out_meta(s_meta)
   );

   ssq_div u_div (
      .clock(clock), .reset(reset), .en(en), .in_valid(s_valid), .in_root(s_root),
      .in_meta(s_meta), .cfg(cfg), .out_valid(d_valid), .out_quot(d_quot),
      .out_meta(d_meta)
   );

   ssq_back u_back (
      .clock(clock), .reset(reset), .en(en), .in_valid(d_valid), .in_quot(d_quot),
      .in_meta(d_meta), .cfg(cfg), .out_valid(rsp_valid), .out_data(rsp_data)
   );

endmodule
